// ----- sv/ssp_pkg.sv -----
// Shared types and constants for the stable sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 16;

  // Fixed field widths of the channels
  localparam int IN_KEY_W  = 16;
  localparam int TAG_W     = 16;
  localparam int OUT_KEY_W = 16;
  localparam int OCC_W     = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/ssp_cell.sv -----
// One slot of the sorted chain: holds a key and tag, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ssp_cell #(
  parameter int KEY_WIDTH = ssp_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire ssp_pkg::cell_ctrl_t      ctrl_i,
  input  wire logic                     occupied_i,
  input  wire logic [KEY_WIDTH-1:0]     new_key_i,
  input  wire logic [ssp_pkg::TAG_W-1:0] new_tag_i,
  input  wire logic                     left_keep_i,
  input  wire logic [KEY_WIDTH-1:0]     left_key_i,
  input  wire logic [ssp_pkg::TAG_W-1:0] left_tag_i,
  input  wire logic [KEY_WIDTH-1:0]     right_key_i,
  input  wire logic [ssp_pkg::TAG_W-1:0] right_tag_i,
  output logic                          keep_o,
  output logic [KEY_WIDTH-1:0]          key_o,
  output logic [ssp_pkg::TAG_W-1:0]     tag_o
);

  logic [KEY_WIDTH-1:0]      key_r, key_nxt;
  logic [ssp_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic                      keep;

  // Stay put on insert when holding an entry not greater than the new key
  assign keep = occupied_i && (key_r <= new_key_i);

  // Choose hold, take new, shift from left, or shift from right
  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl_i.ins) begin
      if (!keep) begin
        if (left_keep_i) begin
          key_nxt = new_key_i;
          tag_nxt = new_tag_i;
        end else begin
          key_nxt = left_key_i;
          tag_nxt = left_tag_i;
        end
      end
    end else if (ctrl_i.pop) begin
      key_nxt = right_key_i;
      tag_nxt = right_tag_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign keep_o = keep;
  assign key_o  = key_r;
  assign tag_o  = tag_r;

endmodule

`default_nettype wire

// ----- sv/stable_sorted_priority_queue.sv -----
// Top level of the stable sorted priority queue: cell chain, count and result register.
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   insert (in_entry_key, in_entry_tag) or pop of the smallest entry.
//   Output channel (out_valid/out_ready) returns one result per transaction:
//   status, popped key and tag, and the occupancy after the operation.
//   Entries sit in a row of QUEUE_DEPTH cells in ascending key order; equal keys
//   keep arrival order. Every cell compares against the new key at once and
//   either holds, takes the new entry, or shifts from its neighbor, so an
//   operation completes in the cycle it is accepted.
//   The result is registered and appears in the cycle after the input transaction.
//   Throughput: one operation per cycle while results are taken; the single
//   result register is the only buffer between the two channels.
//   Stall: while a result waits with out_ready low, in_ready is low.
//   Reset (rst_n low, synchronous): queue empties, no result pending. Cell
//   contents are not cleared; only cells below the count are ever read.
//   Insert on a full queue is dropped (status full); pop on empty gives status
//   empty with zero key and tag.
`timescale 1ns / 1ps
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_WIDTH   = ssp_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [ssp_pkg::IN_KEY_W-1:0]  in_entry_key,
  input  wire logic [ssp_pkg::TAG_W-1:0]     in_entry_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [ssp_pkg::OUT_KEY_W-1:0]      out_popped_key,
  output logic [ssp_pkg::TAG_W-1:0]          out_popped_tag,
  output logic [ssp_pkg::OCC_W-1:0]          out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  ssp_pkg::status_t out_status_r, out_status_nxt;
  logic [ssp_pkg::OUT_KEY_W-1:0] out_key_r, out_key_nxt;
  logic [ssp_pkg::TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic [ssp_pkg::OCC_W-1:0]     out_occ_r, out_occ_nxt;

  logic                in_fire, is_full, is_empty;
  ssp_pkg::cell_ctrl_t ctrl;
  logic [KEY_WIDTH-1:0] new_key;

  logic [KEY_WIDTH-1:0]      cell_key [QUEUE_DEPTH];
  logic [ssp_pkg::TAG_W-1:0] cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    cell_keep;
  logic [QUEUE_DEPTH-1:0]    cell_occ;

  logic [KEY_WIDTH+ssp_pkg::IN_KEY_W-1:0]  key_in_ext;
  logic [KEY_WIDTH+ssp_pkg::OUT_KEY_W-1:0] key_out_ext;
  logic [CNT_W+ssp_pkg::OCC_W-1:0]         occ_ext;

  // Accept when the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // Fit the input key to the stored key width
  assign key_in_ext = {{KEY_WIDTH{1'b0}}, in_entry_key};
  assign new_key    = key_in_ext[KEY_WIDTH-1:0];

  // Broadcast command to the chain
  assign ctrl.ins = in_fire && (in_operation == ssp_pkg::OP_INSERT) && !is_full;
  assign ctrl.pop = in_fire && (in_operation == ssp_pkg::OP_POP) && !is_empty;

  // Build the cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]      l_key, r_key;
    logic [ssp_pkg::TAG_W-1:0] l_tag, r_tag;
    logic                      l_keep;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_key  = new_key;
      assign l_tag  = in_entry_tag;
    end else begin : g_body
      assign l_keep = cell_keep[i-1];
      assign l_key  = cell_key[i-1];
      assign l_tag  = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_tag = cell_tag[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_tag = cell_tag[i+1];
    end

    ssp_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl_i      (ctrl),
      .occupied_i  (cell_occ[i]),
      .new_key_i   (new_key),
      .new_tag_i   (in_entry_tag),
      .left_keep_i (l_keep),
      .left_key_i  (l_key),
      .left_tag_i  (l_tag),
      .right_key_i (r_key),
      .right_tag_i (r_tag),
      .keep_o      (cell_keep[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  // Fit the head key and the count to the output field widths
  assign key_out_ext = {{ssp_pkg::OUT_KEY_W{1'b0}}, cell_key[0]};
  assign occ_ext     = {{ssp_pkg::OCC_W{1'b0}}, count_nxt};

  // Update count and load the result register
  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_occ_nxt    = out_occ_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = '0;
      out_tag_nxt   = '0;
      out_occ_nxt   = occ_ext[ssp_pkg::OCC_W-1:0];
      unique case (in_operation)
        ssp_pkg::OP_INSERT: begin
          out_status_nxt = is_full ? ssp_pkg::ST_FULL : ssp_pkg::ST_OK;
        end
        ssp_pkg::OP_POP: begin
          if (is_empty) begin
            out_status_nxt = ssp_pkg::ST_EMPTY;
          end else begin
            out_status_nxt = ssp_pkg::ST_OK;
            out_key_nxt    = key_out_ext[ssp_pkg::OUT_KEY_W-1:0];
            out_tag_nxt    = cell_tag[0];
          end
        end
        default: begin
          out_status_nxt = ssp_pkg::ST_OK;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_popped_key = out_key_r;
  assign out_popped_tag = out_tag_r;
  assign out_occupancy  = out_occ_r;

`ifndef NO_ASSERTIONS
  // Count never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // Insert on a full queue reports full and leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_operation == ssp_pkg::OP_INSERT) && is_full
    |=> (out_status_r == ssp_pkg::ST_FULL) && (count_r == CNT_W'(QUEUE_DEPTH)))
    else $error("insert on full queue not dropped");

  // Successful pop returns the head entry's tag and shrinks the count by one
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |=> (out_tag_r == $past(cell_tag[0]))
                 && (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not return the head entry");

  // Head cell holds the smallest of the two front entries
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (cell_key[0] <= cell_key[1]))
    else $error("front entries out of order");
`endif

endmodule

`default_nettype wire
